// ----- hw/rtl/tp_segment_reassembler_macros.svh -----
// assertion shorthands used by the checker of the reassembler
`ifndef TP_SEGMENT_REASSEMBLER_MACROS_SVH
`define TP_SEGMENT_REASSEMBLER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TSR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("reassembler check failed");

// consequent checked in the cycle after the antecedent
`define TSR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("reassembler check failed");

`endif

// ----- hw/rtl/tsr_pkg.sv -----
package tsr_pkg;

	// parameter defaults
	localparam int CHANNELS_DEF     = 4;
	localparam int BUFFER_BYTES_DEF = 4096;

	// field widths
	localparam int OP_W     = 2;
	localparam int KIND_W   = 2;
	localparam int CHAN_W   = 2;
	localparam int DATA_W   = 8;
	localparam int SEGLEN_W = 16;
	localparam int RIDX_W   = 12;
	localparam int LEN_W    = 13;
	localparam int MASK_W   = 4;
	localparam int TIMER_W  = 16;
	localparam int POS_W    = 16;
	localparam int HDR_W    = 32;
	localparam int MODE_W   = 2;

	// header layout
	localparam int unsigned HDR_BYTES = 4;
	localparam int OFF_W    = 30;
	localparam int MORE_BIT = 30;

	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd100;

	// input tdata layout
	localparam int S_CH_LSB     = 0;
	localparam int S_DATA_LSB   = S_CH_LSB + CHAN_W;
	localparam int S_SEGLEN_LSB = S_DATA_LSB + DATA_W;
	localparam int S_RIDX_LSB   = S_SEGLEN_LSB + SEGLEN_W;
	localparam int S_USED_W     = S_RIDX_LSB + RIDX_W;
	localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

	// output tdata layout
	localparam int M_CH_LSB   = 0;
	localparam int M_LEN_LSB  = M_CH_LSB + CHAN_W;
	localparam int M_RD_LSB   = M_LEN_LSB + LEN_W;
	localparam int M_MASK_LSB = M_RD_LSB + DATA_W;
	localparam int M_USED_W   = M_MASK_LSB + MASK_W;
	localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_USED_W;

	typedef enum logic [OP_W-1:0] {
		OP_SEG  = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_SEQ_ERR = 2'd2,
		KIND_TIMEOUT = 2'd3
	} kind_t;

	// channel modes
	localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RX   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DONE = 2'd2;

endpackage

// ----- hw/rtl/tp_segment_reassembler.sv -----
// segment byte or read: accepted, then an ST_SEG context and store update or ST_READ result
// load; tick: accepted, then one channel context read-modify-written per cycle in ST_TICK
// a result sits in the output register and reaches m_tdata in the cycle after its update cycle
// the next item is taken while a result waits; the update cycle stalls only if it brings a
// second result before the first has gone
// reset clears control, the timeout register (to 100) and the context valid bits; the
// message store keeps whatever it holds and needs no clearing pass
module tp_segment_reassembler #(
	parameter int CHANNELS     = tsr_pkg::CHANNELS_DEF,
	parameter int BUFFER_BYTES = tsr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsr_pkg::TIMER_W-1:0]    cfg_wdata,   // rx_timeout_ticks
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// channel, data, segment_length, read_index
	input  logic [tsr_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [tsr_pkg::OP_W-1:0]       s_tuser,     // operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_channel, message_length, read_data, timeout_mask
	output logic [tsr_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [tsr_pkg::KIND_W-1:0]     m_tuser      // kind
);
	import tsr_pkg::*;

	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FILL_W   = $clog2(BUFFER_BYTES + 1);
	localparam int ST_DEPTH = CHANNELS * BUFFER_BYTES;
	localparam int ST_AW    = $clog2(ST_DEPTH);
	localparam int SUM_W    = 18;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEG  = 4'b0010,
		ST_READ = 4'b0100,
		ST_TICK = 4'b1000
	} state_t;

	// per-channel receive context
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FILL_W-1:0]  fill;
		logic [TIMER_W-1:0] timer;
	} ctx_t;

	// sequencer and stream state
	state_t             state_q, state_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [HDR_W-1:0]   hdr_q, hdr_d;
	logic               acc_q, acc_d;
	logic [CH_W-1:0]    tick_idx_q, tick_idx_d;
	logic [MASK_W-1:0]  mask_q, mask_d;
	logic [TIMER_W-1:0] rx_timeout_q;

	// accepted item
	logic [CHAN_W-1:0]   ch_q;
	logic [CH_W-1:0]     ch_idx_q;
	logic                ch_ok_q;
	logic [DATA_W-1:0]   data_q;
	logic [SEGLEN_W-1:0] seglen_q;
	logic                rd_ok_q;

	// input unpacking
	logic                in_xfer;
	op_t                 in_op;
	logic [CHAN_W-1:0]   in_ch;
	logic [RIDX_W-1:0]   in_ridx;
	logic                in_ch_ok;
	logic [CH_W-1:0]     in_ch_idx;

	// context memory
	ctx_t              ctx_mem [CHANNELS];
	ctx_t              ctx_rdata_q;
	logic              ctx_rvld_q;
	logic [CHANNELS-1:0] ctx_vld_q;
	logic              ctx_re, ctx_we;
	logic [CH_W-1:0]   ctx_raddr, ctx_waddr;
	ctx_t              ctx_wdata;
	ctx_t              ctx_cur;

	// message store
	logic [DATA_W-1:0] st_mem [ST_DEPTH];
	logic [DATA_W-1:0] st_rdata_q;
	logic              st_re, st_we;
	logic [ST_AW-1:0]  st_raddr, st_waddr;

	// segment byte update
	logic              pos_last;
	logic [HDR_W-1:0]  hdr_base, hdr_new;
	logic              acc_base, acc_new;
	logic [SEGLEN_W-1:0] payload;
	ctx_t              seg_nxt;
	logic              seg_err, seg_done, seg_st_we;

	// tick update
	ctx_t              tk_nxt;
	logic              tk_we, tk_hit, tick_last;
	logic [MASK_W-1:0] mask_bit, mask_all;

	// output register
	logic              out_free, out_load;
	kind_t             out_kind;
	logic [CHAN_W-1:0] out_ch;
	logic [LEN_W-1:0]  out_len;
	logic [DATA_W-1:0] out_rd;
	logic [MASK_W-1:0] out_mask;
	logic              m_valid_q;
	kind_t             m_kind_q;
	logic [CHAN_W-1:0] m_ch_q;
	logic [LEN_W-1:0]  m_len_q;
	logic [DATA_W-1:0] m_rd_q;
	logic [MASK_W-1:0] m_mask_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign in_op     = op_t'(s_tuser);
	assign in_ch     = s_tdata[S_CH_LSB +: CHAN_W];
	assign in_ridx   = s_tdata[S_RIDX_LSB +: RIDX_W];
	assign in_ch_ok  = (32'(in_ch) < CHANNELS);
	assign in_ch_idx = in_ch_ok ? CH_W'(in_ch) : '0;

	// store read for a read transfer is launched at the accept edge
	assign st_re    = in_xfer && (in_op == OP_READ);
	assign st_raddr = ST_AW'(in_ch_idx) * ST_AW'(BUFFER_BYTES) + ST_AW'(in_ridx);

	// unwritten context entries read as the reset context
	assign ctx_cur = ctx_rvld_q ? ctx_rdata_q : '0;

	// ---------------------------------------------------------------
	// segment byte: header assembly, offset check, payload append
	// ---------------------------------------------------------------
	always_comb begin
		pos_last  = (17'(pos_q) + 17'd1) >= 17'(seglen_q);
		hdr_base  = (pos_q == '0) ? '0 : hdr_q;
		acc_base  = (pos_q == '0) ? 1'b0 : acc_q;
		hdr_new   = (32'(pos_q) < HDR_BYTES) ? {hdr_base[HDR_W-DATA_W-1:0], data_q} : hdr_base;
		payload   = seglen_q - SEGLEN_W'(HDR_BYTES);
		seg_nxt   = ctx_cur;
		acc_new   = acc_base;
		seg_err   = 1'b0;
		seg_st_we = 1'b0;
		if ((32'(pos_q) == HDR_BYTES - 1) && (32'(seglen_q) >= HDR_BYTES) && ch_ok_q) begin
			// offset zero restarts the channel
			if (hdr_new[OFF_W-1:0] == '0) begin
				seg_nxt.mode = MODE_RX;
				seg_nxt.fill = '0;
			end
			if (hdr_new[OFF_W-1:0] == OFF_W'(seg_nxt.fill)) begin
				// oversized payload drops the segment silently
				if (SUM_W'(seg_nxt.fill) + SUM_W'(payload) <= SUM_W'(BUFFER_BYTES)) begin
					acc_new       = 1'b1;
					seg_nxt.timer = rx_timeout_q;
				end
			end else begin
				seg_nxt = '0;
				seg_err = 1'b1;
			end
		end else if ((32'(pos_q) >= HDR_BYTES) && acc_base && ch_ok_q) begin
			if (32'(ctx_cur.fill) < BUFFER_BYTES) begin
				seg_st_we    = 1'b1;
				seg_nxt.fill = ctx_cur.fill + FILL_W'(1);
			end
		end
		seg_done = pos_last && acc_new && ch_ok_q && !hdr_new[MORE_BIT];
		if (seg_done)
			seg_nxt.mode = MODE_DONE;
	end

	assign st_waddr = ST_AW'(ch_idx_q) * ST_AW'(BUFFER_BYTES) + ST_AW'(ctx_cur.fill);

	// ---------------------------------------------------------------
	// tick: count down the channel under the walk pointer
	// ---------------------------------------------------------------
	always_comb begin
		tk_nxt = ctx_cur;
		tk_we  = 1'b0;
		tk_hit = 1'b0;
		if ((ctx_cur.mode == MODE_RX) && (ctx_cur.timer != '0)) begin
			tk_nxt.timer = ctx_cur.timer - TIMER_W'(1);
			tk_we        = 1'b1;
			if (tk_nxt.timer == '0) begin
				tk_nxt = '0;
				tk_hit = 1'b1;
			end
		end
		tick_last = (32'(tick_idx_q) == CHANNELS - 1);
		mask_bit  = (tk_hit && (32'(tick_idx_q) < MASK_W)) ? (MASK_W'(1) << tick_idx_q) : '0;
		mask_all  = mask_q | mask_bit;
	end

	assign out_free = !m_valid_q || m_tready;

	// ---------------------------------------------------------------
	// sequencer: accept, update, walk; holds an update cycle while the
	// output register cannot take its result
	// ---------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		hdr_d      = hdr_q;
		acc_d      = acc_q;
		tick_idx_d = tick_idx_q;
		mask_d     = mask_q;
		ctx_re     = 1'b0;
		ctx_raddr  = '0;
		ctx_we     = 1'b0;
		ctx_waddr  = '0;
		ctx_wdata  = seg_nxt;
		st_we      = 1'b0;
		out_load   = 1'b0;
		out_kind   = KIND_READ;
		out_ch     = ch_q;
		out_len    = '0;
		out_rd     = '0;
		out_mask   = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (in_op)
						OP_SEG: begin
							ctx_re    = 1'b1;
							ctx_raddr = in_ch_idx;
							state_d   = ST_SEG;
						end
						OP_TICK: begin
							ctx_re     = 1'b1;
							ctx_raddr  = '0;
							tick_idx_d = '0;
							mask_d     = '0;
							state_d    = ST_TICK;
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SEG: begin
				if (!(seg_err || seg_done) || out_free) begin
					ctx_we    = ch_ok_q;
					ctx_waddr = ch_idx_q;
					ctx_wdata = seg_nxt;
					st_we     = seg_st_we;
					hdr_d     = hdr_new;
					if (pos_last) begin
						pos_d = '0;
						acc_d = 1'b0;
					end else begin
						pos_d = pos_q + POS_W'(1);
						acc_d = acc_new;
					end
					if (seg_err) begin
						out_load = 1'b1;
						out_kind = KIND_SEQ_ERR;
					end else if (seg_done) begin
						out_load = 1'b1;
						out_kind = KIND_DONE;
						out_len  = LEN_W'(seg_nxt.fill);
					end
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind = KIND_READ;
					out_rd   = rd_ok_q ? st_rdata_q : '0;
					state_d  = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (!(tick_last && (mask_all != '0)) || out_free) begin
					ctx_we    = tk_we;
					ctx_waddr = tick_idx_q;
					ctx_wdata = tk_nxt;
					mask_d    = mask_all;
					if (tick_last) begin
						if (mask_all != '0) begin
							out_load = 1'b1;
							out_kind = KIND_TIMEOUT;
							out_ch   = '0;
							out_mask = mask_all;
						end
						state_d = ST_IDLE;
					end else begin
						// next channel's read overlaps this channel's write-back
						ctx_re     = 1'b1;
						ctx_raddr  = tick_idx_q + CH_W'(1);
						tick_idx_d = tick_idx_q + CH_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// context memory, registered read
	always_ff @(posedge clk) begin
		if (ctx_we)
			ctx_mem[ctx_waddr] <= ctx_wdata;
		if (ctx_re)
			ctx_rdata_q <= ctx_mem[ctx_raddr];
	end

	// written marks for the context entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_vld_q  <= '0;
			ctx_rvld_q <= 1'b0;
		end else begin
			if (ctx_we)
				ctx_vld_q[ctx_waddr] <= 1'b1;
			if (ctx_re)
				ctx_rvld_q <= ctx_vld_q[ctx_raddr];
		end
	end

	// message store, registered read
	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[st_waddr] <= data_q;
		if (st_re)
			st_rdata_q <= st_mem[st_raddr];
	end

	// accepted item fields
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q     <= in_ch;
			ch_idx_q <= in_ch_idx;
			ch_ok_q  <= in_ch_ok;
			data_q   <= s_tdata[S_DATA_LSB +: DATA_W];
			seglen_q <= s_tdata[S_SEGLEN_LSB +: SEGLEN_W];
			rd_ok_q  <= in_ch_ok && (32'(in_ridx) < BUFFER_BYTES);
		end
	end

	// control state and timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			hdr_q        <= '0;
			acc_q        <= 1'b0;
			tick_idx_q   <= '0;
			mask_q       <= '0;
			rx_timeout_q <= TIMEOUT_RESET;
			m_valid_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			hdr_q      <= hdr_d;
			acc_q      <= acc_d;
			tick_idx_q <= tick_idx_d;
			mask_q     <= mask_d;
			if (cfg_we)
				rx_timeout_q <= cfg_wdata;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_kind_q <= out_kind;
			m_ch_q   <= out_ch;
			m_len_q  <= out_len;
			m_rd_q   <= out_rd;
			m_mask_q <= out_mask;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_mask_q, m_rd_q, m_len_q, m_ch_q};

endmodule

// ----- hw/rtl/tsr_checker.sv -----
`include "tp_segment_reassembler_macros.svh"

module tsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [tsr_pkg::OP_W-1:0]      s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tsr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [tsr_pkg::KIND_W-1:0]    m_tuser
);
	import tsr_pkg::*;

	// any real operation keeps the input side closed for its update cycle
	`TSR_ASSERT_NEXT(a_busy_after_op, clk, arst_n, s_tvalid && s_tready && (s_tuser != OP_NOP), !s_tready)

	// a stalled result holds
	`TSR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a timeout names channels by mask only
	`TSR_ASSERT_NOW(a_timeout_shape, clk, arst_n, m_tvalid && (m_tuser == KIND_TIMEOUT), (m_tdata[M_MASK_LSB +: MASK_W] != '0) && (m_tdata[M_CH_LSB +: CHAN_W] == '0) && (m_tdata[M_LEN_LSB +: LEN_W] == '0) && (m_tdata[M_RD_LSB +: DATA_W] == '0))

	// only a timeout carries a mask
	`TSR_ASSERT_NOW(a_mask_only_timeout, clk, arst_n, m_tvalid && (m_tuser != KIND_TIMEOUT), m_tdata[M_MASK_LSB +: MASK_W] == '0)

endmodule

bind tp_segment_reassembler tsr_checker u_tsr_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// segment reassembler: transfers are sent through the input stream, a local mirror
// of the channel contexts and the message store works out the expected result of each
// accepted transfer, and every result on the output stream is compared with the oldest
// one still owed
module testbench;
	import tsr_pkg::*;

	localparam int NUM_CH        = CHANNELS_DEF;
	localparam int BUF_BYTES     = BUFFER_BYTES_DEF;
	localparam int CLK_PERIOD    = 20;
	localparam int SETTLE_CYCLES = 16;      // a tick walks every channel, then the output register
	localparam int CYCLE_LIMIT   = 600_000;

	// one result as it leaves the block
	typedef struct packed {
		kind_t             kind;
		logic [CHAN_W-1:0] chan;
		logic [LEN_W-1:0]  msg_len;
		logic [DATA_W-1:0] rd_byte;
		logic [MASK_W-1:0] tmo_mask;
	} result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMER_W-1:0]   cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [OP_W-1:0]      s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;

	// mirror of the channel contexts, the segment parser and the message store
	logic [MODE_W-1:0]  chan_mode    [NUM_CH];
	logic [LEN_W-1:0]   chan_fill    [NUM_CH];
	logic [TIMER_W-1:0] chan_timer   [NUM_CH];
	int unsigned        chan_written [NUM_CH];   // bytes below this index hold known data
	logic [DATA_W-1:0]  msg_mem      [NUM_CH][BUF_BYTES];
	int unsigned        seg_pos;
	logic [HDR_W-1:0]   seg_hdr;
	bit                 seg_taken;
	logic [TIMER_W-1:0] reload_ticks;

	result_t     owed_results[$];   // results still to arrive, oldest first
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned cycle_count;
	bit          src_gaps;           // sender leaves random gaps
	bit          sink_stalls;        // receiver drops tready at random

	tp_segment_reassembler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver side: tready changes on the falling edge only
	always @(negedge clk)
		m_tready <= !(sink_stalls && ($urandom_range(99) < 38));

	function automatic void drop_channel(input int c);
		chan_mode[c]  = MODE_IDLE;
		chan_fill[c]  = '0;
		chan_timer[c] = '0;
	endfunction

	// next state of the mirror for one accepted transfer; returns 1 when a result is due
	function automatic bit predict_outcome(input op_t op, input logic [CHAN_W-1:0] ch,
			input logic [DATA_W-1:0] d, input logic [SEGLEN_W-1:0] sl,
			input logic [RIDX_W-1:0] ri, output result_t r);
		int          c;
		int unsigned len;
		int unsigned offset;
		int unsigned payload;
		bit          last;
		bit          hit;
		c   = int'(ch);
		len = int'(sl);
		hit = 1'b0;
		r   = '0;
		case (op)
			OP_SEG: begin
				last = (seg_pos + 1) >= len;
				if (seg_pos == 0) begin
					seg_hdr   = '0;
					seg_taken = 1'b0;
				end
				if (seg_pos < HDR_BYTES)
					seg_hdr = {seg_hdr[HDR_W-9:0], d};
				if (seg_pos == HDR_BYTES - 1 && len >= HDR_BYTES) begin
					// header complete: offset decides restart, append or sequence error
					offset  = int'(seg_hdr[OFF_W-1:0]);
					payload = len - HDR_BYTES;
					if (offset == 0) begin
						chan_mode[c] = MODE_RX;
						chan_fill[c] = '0;
					end
					if (offset == int'(chan_fill[c])) begin
						// a payload that would overrun the buffer drops the segment quietly
						if (int'(chan_fill[c]) + payload <= BUF_BYTES) begin
							seg_taken     = 1'b1;
							chan_timer[c] = reload_ticks;
						end
					end else begin
						drop_channel(c);
						r.kind = KIND_SEQ_ERR;
						r.chan = ch;
						hit    = 1'b1;
					end
				end else if (seg_pos >= HDR_BYTES && seg_taken) begin
					if (chan_fill[c] < BUF_BYTES) begin
						msg_mem[c][chan_fill[c]] = d;
						chan_fill[c]++;
						if (int'(chan_fill[c]) > chan_written[c])
							chan_written[c] = int'(chan_fill[c]);
					end
				end
				if (last) begin
					if (seg_taken && !seg_hdr[MORE_BIT]) begin
						chan_mode[c] = MODE_DONE;
						r.kind       = KIND_DONE;
						r.chan       = ch;
						r.msg_len    = chan_fill[c];
						hit          = 1'b1;
					end
					seg_pos   = 0;
					seg_taken = 1'b0;
				end else begin
					seg_pos = (seg_pos + 1) & 32'hFFFF;
				end
			end
			OP_TICK: begin
				// only receiving channels with a running timer count down
				for (int i = 0; i < NUM_CH; i++) begin
					if (chan_mode[i] == MODE_RX && chan_timer[i] != '0) begin
						chan_timer[i]--;
						if (chan_timer[i] == '0) begin
							drop_channel(i);
							r.tmo_mask[i] = 1'b1;
						end
					end
				end
				r.kind = KIND_TIMEOUT;
				hit    = r.tmo_mask != '0;
			end
			OP_READ: begin
				r.kind    = KIND_READ;
				r.chan    = ch;
				r.rd_byte = msg_mem[c][ri];
				hit       = 1'b1;
			end
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// one transfer on the input stream, with random gaps ahead of it
	task automatic send_item(input op_t op, input logic [CHAN_W-1:0] ch,
			input logic [DATA_W-1:0] d, input logic [SEGLEN_W-1:0] sl,
			input logic [RIDX_W-1:0] ri);
		logic [S_TDATA_W-1:0] word;
		result_t              r;
		word                           = '0;
		word[S_CH_LSB +: CHAN_W]       = ch;
		word[S_DATA_LSB +: DATA_W]     = d;
		word[S_SEGLEN_LSB +: SEGLEN_W] = sl;
		word[S_RIDX_LSB +: RIDX_W]     = ri;
		while (src_gaps && ($urandom_range(99) < 38)) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// transfer taken at this edge
		if (predict_outcome(op, ch, d, sl, ri, r))
			owed_results.push_back(r);
		if (op != OP_NOP)
			items_sent++;
	endtask

	task automatic send_tick;
		send_item(OP_TICK, CHAN_W'($urandom), DATA_W'($urandom), SEGLEN_W'($urandom),
			RIDX_W'($urandom));
	endtask

	// one whole segment, header first; mangle breaks it up now and then
	task automatic send_segment(input logic [CHAN_W-1:0] ch, input logic [OFF_W-1:0] offset,
			input bit more, input int unsigned payload, input bit mangle,
			input logic [SEGLEN_W-1:0] hdr_len);
		logic [HDR_W-1:0]    hdr;
		logic [SEGLEN_W-1:0] byte_len;
		logic [CHAN_W-1:0]   byte_ch;
		logic [DATA_W-1:0]   d;
		int                  seg_len;
		bit                  cut;
		hdr     = {1'($urandom_range(1)), more, offset};
		seg_len = int'(payload) + int'(HDR_BYTES);
		for (int i = 0; i < seg_len; i++) begin
			d        = (i < HDR_BYTES) ? hdr[HDR_W-1-8*i -: 8] : DATA_W'($urandom);
			byte_len = SEGLEN_W'(seg_len);
			byte_ch  = ch;
			cut      = 1'b0;
			// the header byte may carry a length other than the true one
			if (i == HDR_BYTES - 1 && hdr_len != '0)
				byte_len = hdr_len;
			if (mangle) begin
				if (i >= HDR_BYTES && i + 1 < seg_len && $urandom_range(3) == 0)
					byte_len = SEGLEN_W'($urandom_range(65535, i + 2));
				if ($urandom_range(19) == 0)
					byte_ch = CHAN_W'($urandom);
				if (i >= 1 && i + 1 < seg_len && $urandom_range(29) == 0) begin
					byte_len = SEGLEN_W'($urandom_range(i + 1));
					cut      = 1'b1;
				end
			end
			send_item(OP_SEG, byte_ch, d, byte_len, RIDX_W'($urandom));
			if (cut)
				break;
		end
	endtask

	// segment shorter than a header: its bytes are only consumed
	task automatic send_short_segment(input logic [CHAN_W-1:0] ch, input int unsigned len);
		for (int i = 0; i < ((len == 0) ? 1 : len); i++)
			send_item(OP_SEG, ch, DATA_W'($urandom), SEGLEN_W'(len), RIDX_W'($urandom));
	endtask

	// stop sending and wait until every owed result has come and the block is quiet
	task automatic drain_and_settle;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMER_W-1:0] ticks);
		drain_and_settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we       <= 1'b0;
		reload_ticks  = ticks;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result side: every output transfer is matched with the oldest owed result
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				$error("result of kind %0d with none owed", m_tuser);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("result_channel", want.chan, m_tdata[M_CH_LSB +: CHAN_W]);
				check_field("message_length", want.msg_len, m_tdata[M_LEN_LSB +: LEN_W]);
				check_field("read_data", want.rd_byte, m_tdata[M_RD_LSB +: DATA_W]);
				check_field("timeout_mask", want.tmo_mask, m_tdata[M_MASK_LSB +: MASK_W]);
			end
		end
	end

	// single and two-segment messages, an empty segment, reads back
	task automatic test_basic_messages;
		send_segment(2'd0, '0, 1'b0, 3, 1'b0, '0);
		send_segment(2'd1, '0, 1'b1, 4, 1'b0, '0);
		send_segment(2'd1, OFF_W'(4), 1'b0, 2, 1'b0, '0);
		send_segment(2'd2, '0, 1'b0, 0, 1'b0, '0);
		send_item(OP_READ, 2'd0, '0, '0, '0);
		send_item(OP_READ, 2'd1, '1, '1, RIDX_W'(5));
	endtask

	// short segments, offset mismatches, appends to finished messages, oversized header
	task automatic test_segment_corner_cases;
		for (int unsigned len = 0; len < HDR_BYTES; len++)
			send_short_segment(2'd3, len);
		send_segment(2'd3, OFF_W'(5), 1'b0, 1, 1'b0, '0);   // idle channel, wrong offset
		send_segment(2'd1, OFF_W'(6), 1'b0, 1, 1'b0, '0);   // append to finished message
		send_segment(2'd0, '0, 1'b1, 2, 1'b0, '0);          // restart finished channel
		send_segment(2'd0, OFF_W'(1), 1'b1, 1, 1'b0, '0);   // wrong offset while receiving
		send_segment(2'd2, '0, 1'b0, 2, 1'b0, '1);          // header claims far too much payload
		send_item(OP_NOP, '1, '1, '1, '1);
	endtask

	// timer reloads: short, disabled, longest, single tick
	task automatic test_timeouts;
		write_timeout(TIMER_W'(2));
		send_segment(2'd3, '0, 1'b1, 1, 1'b0, '0);
		send_segment(2'd2, '0, 1'b1, 0, 1'b0, '0);
		repeat (2) send_tick();
		write_timeout('0);
		send_segment(2'd1, '0, 1'b1, 1, 1'b0, '0);
		repeat (3) send_tick();
		write_timeout('1);
		send_segment(2'd3, '0, 1'b1, 2, 1'b0, '0);
		send_tick();
		write_timeout(TIMER_W'(1));
		send_segment(2'd0, '0, 1'b1, 0, 1'b0, '0);
		send_tick();
	endtask

	// one message filling the whole buffer, then one byte too many
	task automatic test_full_buffer;
		write_timeout(TIMEOUT_RESET);
		send_segment(2'd0, '0, 1'b0, BUF_BYTES, 1'b0, '0);
		send_segment(2'd0, OFF_W'(BUF_BYTES), 1'b0, 1, 1'b0, '0);
		send_item(OP_READ, 2'd0, '0, '0, RIDX_W'(BUF_BYTES - 1));
		send_item(OP_READ, 2'd0, '0, '0, RIDX_W'(BUF_BYTES / 2));
	endtask

	// mostly well-formed segments with random content, plus ticks, reads and noise
	task automatic run_traffic(input int unsigned n_items);
		int unsigned       stop_at;
		int unsigned       pick;
		logic [CHAN_W-1:0] ch;
		logic [OFF_W-1:0]  offset;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			ch   = CHAN_W'($urandom);
			if (pick < 62) begin
				pick = $urandom_range(99);
				if (pick < 30)
					offset = '0;
				else if (pick < 80)
					offset = OFF_W'(chan_fill[ch]);
				else if (pick < 90)
					offset = OFF_W'(int'(chan_fill[ch]) + $urandom_range(9, 1));
				else
					offset = OFF_W'($urandom);
				send_segment(ch, offset, 1'($urandom_range(1)),
					($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10),
					$urandom_range(4) == 0,
					($urandom_range(19) == 0) ? SEGLEN_W'($urandom_range(65535, 4101)) : '0);
			end else if (pick < 68) begin
				send_short_segment(ch, $urandom_range(3));
			end else if (pick < 82) begin
				send_tick();
			end else if (pick < 97) begin
				// reads only reach bytes already written; channel 0 is full by now
				if (chan_written[ch] == 0)
					ch = '0;
				send_item(OP_READ, ch, DATA_W'($urandom), SEGLEN_W'($urandom),
					RIDX_W'($urandom_range(chan_written[ch] - 1)));
			end else begin
				send_item(OP_NOP, ch, DATA_W'($urandom), SEGLEN_W'($urandom),
					RIDX_W'($urandom));
			end
		end
	endtask

	task automatic test_random_traffic;
		write_timeout(TIMER_W'($urandom_range(40, 8)));
		run_traffic(250);
		// a long stretch at full rate on both sides
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		write_timeout(TIMER_W'($urandom_range(20, 4)));
		run_traffic(200);
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		write_timeout(TIMER_W'(1));
		run_traffic(150);
		write_timeout(TIMER_W'($urandom));
		run_traffic(200);
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_NOP;
		m_tready    = 1'b0;
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		mismatches  = 0;
		items_sent  = 0;
		cycle_count = 0;
		// mirror starts from the reset state; the store holds nothing known yet
		for (int c = 0; c < NUM_CH; c++) begin
			drop_channel(c);
			chan_written[c] = 0;
		end
		seg_pos      = 0;
		seg_hdr      = '0;
		seg_taken    = 1'b0;
		reload_ticks = TIMEOUT_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_messages();
		test_segment_corner_cases();
		test_timeouts();
		test_full_buffer();
		test_random_traffic();

		drain_and_settle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
